// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/shs_pkg.sv =====
package shs_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  // Working variables a..h of the compression.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } vars_t;

  localparam int unsigned BlockBits = 512;
  localparam logic [7:0]  PadMark   = 8'h80;
  localparam logic [5:0]  LenFill   = 6'd56;
  localparam logic [5:0]  LastFill  = 6'd63;
  localparam logic [5:0]  LastRound = 6'd63;
  localparam logic [2:0]  LastWord  = 3'd7;
  localparam logic [63:0] BitsPerByte = 64'd8;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== src/shs_if.sv =====
// Input channel: one message byte, an end mark, or both per item.
interface shs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

// Result channel: one digest word per item.
interface shs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== src/sha256_stream_hasher.sv =====
// Streaming SHA-256. Message bytes are taken one per cycle while the 64-byte
// block fills; the item that completes a block starts a compression of a load
// step, the rounds (one shared round unit) and a final step that adds the
// result into the hash, during which no item is taken. On the end item the
// sequencer appends the padding itself at one byte per cycle (9 to 72 bytes,
// with one further compression when the length does not fit), then presents
// the eight digest words, h0 first, one per cycle as the sink takes them, and
// returns to the initial hash for the next message. The block buffer doubles
// as the rolling message schedule and needs no clearing after reset.
`include "assert_macros.svh"

module sha256_stream_hasher (
  input  logic            clk,
  input  logic            rst_n,
  shs_in_if.sink          in_chan,
  shs_out_if.source       out_chan
);

  shs_pkg::state_t state_r, state_nxt;

  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  count_r, count_nxt;
  logic         pad_r, pad_nxt;
  logic         mark_r, mark_nxt;
  logic         lenph_r, lenph_nxt;
  logic [2:0]   lidx_r, lidx_nxt;
  logic         done_r, done_nxt;
  logic [5:0]   round_r, round_nxt;
  logic [2:0]   oidx_r, oidx_nxt;
  logic [shs_pkg::BlockBits-1:0] blk_r, blk_nxt;
  shs_pkg::vars_t vars_r, vars_nxt;
  logic [31:0]  wk_r, wk_nxt;
  logic [31:0]  hash_r [8];
  logic [31:0]  hash_nxt [8];

  logic         push;
  logic [7:0]   push_byte;
  logic         is_len;
  logic [7:0]   len_byte;
  logic [7:0]   pad_byte;
  logic [5:0]   sched_j;
  logic         sched_step;
  shs_pkg::vars_t round_out;
  logic [31:0]  wnew;

  // Shared round and schedule unit.
  shs_round u_round (
    .cur    (vars_r),
    .wk     (wk_r),
    .w0     (blk_r[511:480]),
    .w1     (blk_r[479:448]),
    .w9     (blk_r[223:192]),
    .w14    (blk_r[63:32]),
    .expand (sched_j[5:4] != 2'b00),
    .nxt    (round_out),
    .wnew   (wnew)
  );

  // Padding byte: the mark, zeros up to byte 56, then the big-endian length.
  always_comb begin
    is_len   = mark_r && (lenph_r || (fill_r == shs_pkg::LenFill));
    len_byte = 8'(count_r >> {3'd7 - lidx_r, 3'b000});
    if (!mark_r) begin
      pad_byte = shs_pkg::PadMark;
    end else if (is_len) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Sequencer: next state, handshakes and the control registers.
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    count_nxt  = count_r;
    pad_nxt    = pad_r;
    mark_nxt   = mark_r;
    lenph_nxt  = lenph_r;
    lidx_nxt   = lidx_r;
    done_nxt   = done_r;
    round_nxt  = round_r;
    oidx_nxt   = oidx_r;
    vars_nxt   = vars_r;
    hash_nxt   = hash_r;
    push       = 1'b0;
    push_byte  = in_chan.data_byte;
    sched_j    = 6'd0;
    sched_step = 1'b0;
    in_chan.ready  = 1'b0;
    out_chan.valid = 1'b0;

    case (state_r)
      shs_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          if (in_chan.has_byte) begin
            push      = 1'b1;
            count_nxt = count_r + shs_pkg::BitsPerByte;
          end
          if (in_chan.end_of_message) begin
            pad_nxt = 1'b1;
          end
          if (in_chan.has_byte && (fill_r == shs_pkg::LastFill)) begin
            state_nxt = shs_pkg::ST_LOAD;
          end else if (in_chan.end_of_message) begin
            state_nxt = shs_pkg::ST_PAD;
          end
        end
      end

      shs_pkg::ST_PAD: begin
        push      = 1'b1;
        push_byte = pad_byte;
        mark_nxt  = 1'b1;
        if (is_len) begin
          lenph_nxt = 1'b1;
          lidx_nxt  = lidx_r + 3'd1;
          if (lidx_r == shs_pkg::LastWord) begin
            done_nxt = 1'b1;
          end
        end
        if (fill_r == shs_pkg::LastFill) begin
          state_nxt = shs_pkg::ST_LOAD;
        end
      end

      shs_pkg::ST_LOAD: begin
        vars_nxt   = {hash_r[0], hash_r[1], hash_r[2], hash_r[3],
                      hash_r[4], hash_r[5], hash_r[6], hash_r[7]};
        sched_step = 1'b1;
        round_nxt  = 6'd0;
        state_nxt  = shs_pkg::ST_ROUND;
      end

      shs_pkg::ST_ROUND: begin
        vars_nxt  = round_out;
        sched_j   = round_r + 6'd1;
        round_nxt = round_r + 6'd1;
        if (round_r == shs_pkg::LastRound) begin
          state_nxt = shs_pkg::ST_FINAL;
        end else begin
          sched_step = 1'b1;
        end
      end

      shs_pkg::ST_FINAL: begin
        hash_nxt[0] = hash_r[0] + vars_r.a;
        hash_nxt[1] = hash_r[1] + vars_r.b;
        hash_nxt[2] = hash_r[2] + vars_r.c;
        hash_nxt[3] = hash_r[3] + vars_r.d;
        hash_nxt[4] = hash_r[4] + vars_r.e;
        hash_nxt[5] = hash_r[5] + vars_r.f;
        hash_nxt[6] = hash_r[6] + vars_r.g;
        hash_nxt[7] = hash_r[7] + vars_r.h;
        if (done_r) begin
          oidx_nxt  = 3'd0;
          state_nxt = shs_pkg::ST_EMIT;
        end else if (pad_r) begin
          state_nxt = shs_pkg::ST_PAD;
        end else begin
          state_nxt = shs_pkg::ST_IDLE;
        end
      end

      shs_pkg::ST_EMIT: begin
        out_chan.valid = 1'b1;
        if (out_chan.ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == shs_pkg::LastWord) begin
            hash_nxt  = shs_pkg::InitHash;
            count_nxt = 64'd0;
            pad_nxt   = 1'b0;
            mark_nxt  = 1'b0;
            lenph_nxt = 1'b0;
            lidx_nxt  = 3'd0;
            done_nxt  = 1'b0;
            state_nxt = shs_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = shs_pkg::ST_IDLE;
      end
    endcase

    if (push) begin
      fill_nxt = fill_r + 6'd1;
    end
  end

  // Block buffer: bytes shift in at the bottom; during compression it
  // rolls one schedule word per cycle.
  always_comb begin
    blk_nxt = blk_r;
    wk_nxt  = wk_r;
    if (push) begin
      blk_nxt = {blk_r[shs_pkg::BlockBits-9:0], push_byte};
    end else if (sched_step) begin
      blk_nxt = {blk_r[shs_pkg::BlockBits-33:0], wnew};
      wk_nxt  = shs_pkg::RoundK[sched_j] + wnew;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shs_pkg::ST_IDLE;
      fill_r  <= 6'd0;
      count_r <= 64'd0;
      pad_r   <= 1'b0;
      mark_r  <= 1'b0;
      lenph_r <= 1'b0;
      lidx_r  <= 3'd0;
      done_r  <= 1'b0;
      round_r <= 6'd0;
      oidx_r  <= 3'd0;
      hash_r  <= shs_pkg::InitHash;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
      pad_r   <= pad_nxt;
      mark_r  <= mark_nxt;
      lenph_r <= lenph_nxt;
      lidx_r  <= lidx_nxt;
      done_r  <= done_nxt;
      round_r <= round_nxt;
      oidx_r  <= oidx_nxt;
      hash_r  <= hash_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    blk_r  <= blk_nxt;
    vars_r <= vars_nxt;
    wk_r   <= wk_nxt;
  end

  // Result item straight from the held hash words.
  assign out_chan.digest_word = hash_r[oidx_r];
  assign out_chan.word_index  = oidx_r;
  assign out_chan.last_word   = (oidx_r == shs_pkg::LastWord);

  // Checks on the sequencer.
  `ASSERT_ALWAYS(a_no_accept_while_emitting, !(out_chan.valid && in_chan.ready), "input taken during digest output")
  `ASSERT_NEXT(a_rounds_end_in_final, (state_r == shs_pkg::ST_ROUND) && (round_r == shs_pkg::LastRound), state_r == shs_pkg::ST_FINAL, "compression did not finish after the last round")
  `ASSERT_ALWAYS(a_emit_block_aligned, (state_r != shs_pkg::ST_EMIT) || (fill_r == 6'd0), "digest output with a partly filled block")
  `ASSERT_NEXT(a_restart_after_digest, out_chan.valid && out_chan.ready && out_chan.last_word, (count_r == 64'd0) && (hash_r[0] == shs_pkg::InitHash[0]) && !pad_r, "state not restored after the digest")

endmodule

// ===== src/shs_round.sv =====
// One SHA-256 round and one message schedule word: the shared unit that the
// sequencer steps through sixty-four times per block.
module shs_round (
  input  shs_pkg::vars_t cur,
  input  logic [31:0]    wk,
  input  logic [31:0]    w0,
  input  logic [31:0]    w1,
  input  logic [31:0]    w9,
  input  logic [31:0]    w14,
  input  logic           expand,
  output shs_pkg::vars_t nxt,
  output logic [31:0]    wnew
);

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  // Schedule word: the first sixteen come straight from the block.
  always_comb begin
    if (expand) begin
      wnew = shs_pkg::small_sigma1(w14) + w9 + shs_pkg::small_sigma0(w1) + w0;
    end else begin
      wnew = w0;
    end
  end

  // Compression round, with K and W already summed into wk.
  always_comb begin
    ch    = (cur.e & cur.f) ^ (~cur.e & cur.g);
    maj   = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
    t1    = cur.h + shs_pkg::big_sigma1(cur.e) + ch + wk;
    t2    = shs_pkg::big_sigma0(cur.a) + maj;
    nxt.a = t1 + t2;
    nxt.b = cur.a;
    nxt.c = cur.b;
    nxt.d = cur.c;
    nxt.e = cur.d + t1;
    nxt.f = cur.e;
    nxt.g = cur.f;
    nxt.h = cur.g;
  end

endmodule
